// File: sv/terminal_key_sequence_decoder_unit_defines.svh
// Assertion shorthands for the key decoder checker.
// Each expects clk and arst_n in the scope where it is used.
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_UNIT_DEFINES_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define TKSD_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define TKSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Property checked at every edge, reset included.
`define TKSD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/tksd_pkg.sv
`default_nettype none
package tksd_pkg;

	localparam int ByteW    = 8;
	localparam int CodeW    = 21;
	// Only the first CSI parameter can select a key, so only it is kept.
	localparam int ParamWidth = 16;
	localparam int CountW   = 4;
	localparam int UCountW  = 3;

	typedef enum logic [1:0] {
		ModeNormal = 2'd0,
		ModeEsc    = 2'd1,
		ModeCsi    = 2'd2
	} mode_t;

	localparam logic [ByteW-1:0] ByteEsc   = 8'd27;
	localparam logic [ByteW-1:0] ByteDel   = 8'd127;
	localparam logic [ByteW-1:0] ByteLbr   = 8'h5B;
	localparam logic [ByteW-1:0] ByteTilde = 8'h7E;
	localparam logic [ByteW-1:0] ByteSemi  = 8'h3B;
	localparam logic [ByteW-1:0] ByteZero  = 8'h30;
	localparam logic [ByteW-1:0] ByteNine  = 8'h39;
	localparam logic [ByteW-1:0] ByteUp    = 8'h41;
	localparam logic [ByteW-1:0] ByteDown  = 8'h42;
	localparam logic [ByteW-1:0] ByteRight = 8'h43;
	localparam logic [ByteW-1:0] ByteLeft  = 8'h44;

	localparam logic [CodeW-1:0] KeyHome  = 21'h01;
	localparam logic [CodeW-1:0] KeyBksp  = 21'h08;
	localparam logic [CodeW-1:0] KeyEnd   = 21'h05;
	localparam logic [CodeW-1:0] KeyUp    = 21'h10;
	localparam logic [CodeW-1:0] KeyDown  = 21'h0E;
	localparam logic [CodeW-1:0] KeyRight = 21'h06;
	localparam logic [CodeW-1:0] KeyLeft  = 21'h02;

	typedef struct packed {
		mode_t                  mode;
		logic [ParamWidth-1:0]  param0;
		logic [CountW-1:0]      pcnt;
		logic [UCountW-1:0]     ucnt;
		logic [ByteW-1:0]       lead;
		logic [ByteW-1:0]       cont1;
		logic [ByteW-1:0]       cont2;
	} dec_state_t;

	typedef struct packed {
		logic             hit;
		logic [CodeW-1:0] code;
	} dec_result_t;

endpackage
`default_nettype wire

// File: sv/tksd_byte_if.sv
`default_nettype none
interface tksd_byte_if;
	logic                        valid;
	logic                        ready;
	logic [tksd_pkg::ByteW-1:0]  in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// File: sv/tksd_key_if.sv
`default_nettype none
interface tksd_key_if;
	logic                        valid;
	logic                        ready;
	logic [tksd_pkg::CodeW-1:0]  key_code;

	modport source(output valid, output key_code, input ready);
	modport sink(input valid, input key_code, output ready);
endinterface
`default_nettype wire

// File: sv/terminal_key_sequence_decoder_unit.sv
// Terminal key decoder: raw terminal bytes in, key codes and code points out.
// term (sink): one byte per beat on in_byte, taken when valid and ready are high.
// key (source): one 21-bit key_code per beat; a byte yields zero or one beat.
//   DEL gives backspace 0x08, ESC [ ... A/B/C/D and ESC [ n ~ give editing codes,
//   everything else runs through a strict UTF-8 decoder; bad bytes vanish.
// Path: an accepted byte waits in the byte register, is decoded there, and its
//   result loads into the result register, from which its beat is offered.
// Throughput: one byte per cycle unless key stalls. The decode is one pass of
//   shallow compares and a times-ten add between the byte and result registers.
// Stall: while key is valid and not ready the result register holds; an empty byte
//   register still takes one more byte, then term.ready drops until key drains.
// Reset (arst_n low, asynchronous): both registers empty, decoder back to
//   plain mode with no pending escape or UTF-8 bytes.
`default_nettype none
module terminal_key_sequence_decoder_unit (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tksd_byte_if.sink    term,
	tksd_key_if.source   key
);

	logic                           valid_s1;
	logic [tksd_pkg::ByteW-1:0]     byte_s1;
	tksd_pkg::dec_state_t           state_q;
	tksd_pkg::dec_state_t           state_nxt;
	tksd_pkg::dec_result_t          step_res;
	logic                           key_valid_q;
	logic [tksd_pkg::CodeW-1:0]     key_code_q;
	logic                           advance;

	// Decode the held byte once the result register is free or draining.
	assign advance    = valid_s1 && (!key_valid_q || key.ready);
	assign term.ready = !valid_s1 || advance;

	assign key.valid    = key_valid_q;
	assign key.key_code = key_code_q;

	tksd_step u_step (
		.cur     (state_q),
		.in_byte (byte_s1),
		.nxt     (state_nxt),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			key_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (term.ready) valid_s1 <= term.valid;
			if (advance) begin
				state_q     <= state_nxt;
				key_valid_q <= step_res.hit;
			end else if (key.ready) begin
				key_valid_q <= 1'b0;
			end
		end
	end

	// Payload: capture the byte and the result without reset.
	always_ff @(posedge clk) begin
		if (term.valid && term.ready) byte_s1 <= term.in_byte;
		if (advance && step_res.hit) key_code_q <= step_res.code;
	end

endmodule
`default_nettype wire

// File: sv/tksd_step.sv
`default_nettype none
module tksd_step (
	input  tksd_pkg::dec_state_t           cur,
	input  logic [tksd_pkg::ByteW-1:0]     in_byte,
	output tksd_pkg::dec_state_t           nxt,
	output tksd_pkg::dec_result_t          res
);

	function automatic logic [2:0] lead_len(input logic [tksd_pkg::ByteW-1:0] b);
		logic [2:0] n;
		n = 3'd0;
		if (b >= 8'hC2 && b <= 8'hDF) n = 3'd2;
		else if (b >= 8'hE0 && b <= 8'hEF) n = 3'd3;
		else if (b >= 8'hF0 && b <= 8'hF4) n = 3'd4;
		return n;
	endfunction

	function automatic logic cont_ok(input logic [tksd_pkg::ByteW-1:0] lead,
			input logic [tksd_pkg::UCountW-1:0] pos, input logic [tksd_pkg::ByteW-1:0] b);
		logic [tksd_pkg::ByteW-1:0] lo;
		logic [tksd_pkg::ByteW-1:0] hi;
		lo = 8'h80;
		hi = 8'hBF;
		if (pos == 3'd1) begin
			if (lead == 8'hE0) lo = 8'hA0;
			else if (lead == 8'hED) hi = 8'h9F;
			else if (lead == 8'hF0) lo = 8'h90;
			else if (lead == 8'hF4) hi = 8'h8F;
		end
		return (b >= lo) && (b <= hi);
	endfunction

	localparam int AccW = tksd_pkg::ParamWidth + 4;

	logic [2:0]                      need;
	logic                            pend;
	logic                            cont_good;
	logic                            last;
	logic [tksd_pkg::CodeW-1:0]      cp;
	logic                            is_digit;
	logic [AccW-1:0]                 acc;
	logic [tksd_pkg::ParamWidth-1:0] param_sat;

	always_comb begin
		need      = lead_len(cur.lead);
		pend      = (cur.ucnt != '0);
		cont_good = (need != 3'd0) && cont_ok(cur.lead, cur.ucnt, in_byte);
		last      = ((cur.ucnt + 3'd1) == need);
		unique case (need)
			3'd2:    cp = tksd_pkg::CodeW'({cur.lead[4:0], in_byte[5:0]});
			3'd3:    cp = tksd_pkg::CodeW'({cur.lead[3:0], cur.cont1[5:0], in_byte[5:0]});
			default: cp = {cur.lead[2:0], cur.cont1[5:0], cur.cont2[5:0], in_byte[5:0]};
		endcase
	end

	// Times ten plus digit, clamped to the parameter's all-ones value.
	always_comb begin
		is_digit  = (in_byte >= tksd_pkg::ByteZero) && (in_byte <= tksd_pkg::ByteNine);
		acc       = ({4'b0, cur.param0} << 3) + ({4'b0, cur.param0} << 1)
			+ AccW'(in_byte[3:0]);
		param_sat = (acc[AccW-1:tksd_pkg::ParamWidth] != 4'b0) ? '1
			: acc[tksd_pkg::ParamWidth-1:0];
	end

	always_comb begin
		nxt      = cur;
		res.hit  = 1'b0;
		res.code = '0;
		unique case (cur.mode)
			tksd_pkg::ModeNormal: begin
				if (in_byte == tksd_pkg::ByteEsc) begin
					nxt.mode = tksd_pkg::ModeEsc;
				end else if (in_byte == tksd_pkg::ByteDel) begin
					res.hit  = 1'b1;
					res.code = tksd_pkg::KeyBksp;
				end else if (pend && cont_good) begin
					if (last) begin
						res.hit  = 1'b1;
						res.code = cp;
						nxt.ucnt = '0;
					end else begin
						nxt.ucnt = cur.ucnt + 3'd1;
						if (cur.ucnt == 3'd1) nxt.cont1 = in_byte;
						else nxt.cont2 = in_byte;
					end
				end else begin
					// drop any broken sequence and decode this byte as a lead
					nxt.ucnt = '0;
					if (!in_byte[7]) begin
						res.hit  = 1'b1;
						res.code = tksd_pkg::CodeW'(in_byte);
					end else if (lead_len(in_byte) != 3'd0) begin
						nxt.lead = in_byte;
						nxt.ucnt = 3'd1;
					end
				end
			end
			tksd_pkg::ModeEsc: begin
				if (in_byte == tksd_pkg::ByteLbr) begin
					nxt.mode   = tksd_pkg::ModeCsi;
					nxt.param0 = '0;
					nxt.pcnt   = '0;
				end else begin
					nxt.mode = tksd_pkg::ModeNormal;
				end
			end
			tksd_pkg::ModeCsi: begin
				if (is_digit) begin
					if (cur.pcnt == '0) nxt.param0 = param_sat;
				end else begin
					if (cur.pcnt != '1) nxt.pcnt = cur.pcnt + 4'd1;
					if (in_byte != tksd_pkg::ByteSemi) begin
						nxt.mode = tksd_pkg::ModeNormal;
						res.hit  = 1'b1;
						priority if (in_byte == tksd_pkg::ByteUp) res.code = tksd_pkg::KeyUp;
						else if (in_byte == tksd_pkg::ByteDown) res.code = tksd_pkg::KeyDown;
						else if (in_byte == tksd_pkg::ByteRight) res.code = tksd_pkg::KeyRight;
						else if (in_byte == tksd_pkg::ByteLeft) res.code = tksd_pkg::KeyLeft;
						else if (in_byte == tksd_pkg::ByteTilde && cur.pcnt == '0 &&
								cur.param0 == tksd_pkg::ParamWidth'(1))
							res.code = tksd_pkg::KeyHome;
						else if (in_byte == tksd_pkg::ByteTilde && cur.pcnt == '0 &&
								cur.param0 == tksd_pkg::ParamWidth'(3))
							res.code = tksd_pkg::KeyBksp;
						else if (in_byte == tksd_pkg::ByteTilde && cur.pcnt == '0 &&
								cur.param0 == tksd_pkg::ParamWidth'(4))
							res.code = tksd_pkg::KeyEnd;
						else if (in_byte == tksd_pkg::ByteTilde && cur.pcnt == '0 &&
								cur.param0 == tksd_pkg::ParamWidth'(5))
							res.code = tksd_pkg::KeyUp;
						else if (in_byte == tksd_pkg::ByteTilde && cur.pcnt == '0 &&
								cur.param0 == tksd_pkg::ParamWidth'(6))
							res.code = tksd_pkg::KeyDown;
						else res.hit = 1'b0;
					end
				end
			end
			default: begin
				nxt.mode = tksd_pkg::ModeNormal;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: sv/tksd_checker.sv
`default_nettype none
`include "terminal_key_sequence_decoder_unit_defines.svh"
module tksd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        term_valid,
	input wire logic                        term_ready,
	input wire logic                        key_valid,
	input wire logic                        key_ready,
	input wire logic [tksd_pkg::CodeW-1:0]  key_code
);

	logic term_fire;

	assign term_fire = term_valid && term_ready;

	`TKSD_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !key_valid, "key beat offered in reset")
	`TKSD_ASSERT_NEXT(a_key_hold, key_valid && !key_ready, key_valid && $stable(key_code), "stalled key beat changed")
	`TKSD_ASSERT_IMPLY(a_ready_when_empty, !key_valid, term_ready, "term stalled with key side empty")
	`TKSD_ASSERT_IMPLY(a_code_range, key_valid, (key_code <= 21'h10FFFF) && ((key_code < 21'h00D800) || (key_code > 21'h00DFFF)), "key code outside scalar range")

	`TKSD_ASSERT_NEXT(a_fire_known, term_fire, !$isunknown(term_ready), "term ready unknown after a beat")

endmodule

bind terminal_key_sequence_decoder_unit tksd_checker u_tksd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.term_valid (term.valid),
	.term_ready (term.ready),
	.key_valid  (key.valid),
	.key_ready  (key.ready),
	.key_code   (key.key_code)
);
`default_nettype wire
